// ===== rtl/crat_pkg.sv =====
// ----------------------------------------------------------------------------
// crat_pkg
// shared opcodes, step selectors and controller/datapath bundles
// ----------------------------------------------------------------------------
package crat_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_SUB     = 2'd1;
    localparam logic [1:0] OP_COMPARE = 2'd2;

    // multiplier step selectors
    localparam logic [3:0] MUL_RE_P1 = 4'd0;
    localparam logic [3:0] MUL_RE_P2 = 4'd1;
    localparam logic [3:0] MUL_IM_P1 = 4'd2;
    localparam logic [3:0] MUL_IM_P2 = 4'd3;
    localparam logic [3:0] MUL_RE_D  = 4'd4;
    localparam logic [3:0] MUL_IM_D  = 4'd5;
    localparam logic [3:0] MUL_SQ_X1 = 4'd6;
    localparam logic [3:0] MUL_SQ_Y1 = 4'd7;
    localparam logic [3:0] MUL_SQ_X2 = 4'd8;
    localparam logic [3:0] MUL_SQ_Y2 = 4'd9;

    // divider step selectors
    localparam logic [2:0] DIV_RE_N = 3'd0;
    localparam logic [2:0] DIV_RE_D = 3'd1;
    localparam logic [2:0] DIV_IM_N = 3'd2;
    localparam logic [2:0] DIV_IM_D = 3'd3;
    localparam logic [2:0] DIV_X1   = 3'd4;
    localparam logic [2:0] DIV_Y1   = 3'd5;
    localparam logic [2:0] DIV_X2   = 3'd6;
    localparam logic [2:0] DIV_Y2   = 3'd7;

    typedef struct packed {
        logic       in_load;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic       acc_en;
        logic       gcd_start;
        logic       gcd_part;
        logic       div_start;
        logic [2:0] div_sel;
        logic       out_load;
    } crat_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
    } crat_stat_t;

endpackage

// ===== rtl/complex_rational_add_sub.sv =====
// ----------------------------------------------------------------------------
// complex_rational_add_sub
// add, subtract or compare magnitudes of two complex rational numbers
// ----------------------------------------------------------------------------
// One item is worked at a time. Add and subtract run six multiplies on the
// shared multiplier, then per part a binary gcd and two restoring divisions.
// Compare runs four divisions and four squaring multiplies. An unused opcode
// runs no arithmetic. A new item is taken as soon as the previous result sits
// in the output register.
module complex_rational_add_sub import crat_pkg::*; #(
    parameter int PART_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic signed [PART_WIDTH-1:0] s_a_re_num,
    input  logic [PART_WIDTH-2:0]        s_a_re_den,
    input  logic signed [PART_WIDTH-1:0] s_a_im_num,
    input  logic [PART_WIDTH-2:0]        s_a_im_den,
    input  logic signed [PART_WIDTH-1:0] s_b_re_num,
    input  logic [PART_WIDTH-2:0]        s_b_re_den,
    input  logic signed [PART_WIDTH-1:0] s_b_im_num,
    input  logic [PART_WIDTH-2:0]        s_b_im_den,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_sum_re_num,
    output logic [29:0]                  m_sum_re_den,
    output logic signed [31:0]           m_sum_im_num,
    output logic [29:0]                  m_sum_im_den,
    output logic                         m_less_flag
);

    crat_cmd_t  cmd;
    crat_stat_t stat;

    // sequencer
    crat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic
    crat_datapath #(
        .PART_WIDTH (PART_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_opcode     (s_opcode),
        .s_a_re_num   (s_a_re_num),
        .s_a_re_den   (s_a_re_den),
        .s_a_im_num   (s_a_im_num),
        .s_a_im_den   (s_a_im_den),
        .s_b_re_num   (s_b_re_num),
        .s_b_re_den   (s_b_re_den),
        .s_b_im_num   (s_b_im_num),
        .s_b_im_den   (s_b_im_den),
        .m_sum_re_num (m_sum_re_num),
        .m_sum_re_den (m_sum_re_den),
        .m_sum_im_num (m_sum_im_num),
        .m_sum_im_den (m_sum_im_den),
        .m_less_flag  (m_less_flag)
    );

endmodule

// ===== rtl/crat_div.sv =====
// ----------------------------------------------------------------------------
// crat_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module crat_div #(
    parameter int WIDTH = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output logic             done
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH:0]   rem_reg;
    logic [WIDTH-1:0] quo_reg, dsr_reg;
    logic [WIDTH:0]   rem_sh, trial;

    // one shift and trial subtract
    assign rem_sh = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
    assign trial  = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath of the divider
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[WIDTH]) begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/crat_gcd.sv =====
// ----------------------------------------------------------------------------
// crat_gcd
// binary gcd, one subtract or shift step per cycle; zero operand gives 1
// ----------------------------------------------------------------------------
module crat_gcd #(
    parameter int WIDTH = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    output logic [WIDTH-1:0] g,
    output logic             done
);

    localparam int KW = $clog2(WIDTH + 1);

    logic             busy_reg, done_reg;
    logic [WIDTH-1:0] u_reg, v_reg, g_reg;
    logic [KW-1:0]    k_reg;
    logic [WIDTH-1:0] u_minus_v, v_minus_u;

    assign u_minus_v = u_reg - v_reg;
    assign v_minus_u = v_reg - u_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (x == '0 || y == '0) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg && u_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // step through the reduction
    always_ff @(posedge aclk) begin
        if (start) begin
            u_reg <= x;
            v_reg <= y;
            k_reg <= '0;
            g_reg <= WIDTH'(1);
        end else if (busy_reg) begin
            priority if (u_reg == '0) begin
                g_reg <= v_reg << k_reg;
            end else if (!u_reg[0] && !v_reg[0]) begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else if (u_reg >= v_reg) begin
                u_reg <= u_minus_v >> 1;
            end else begin
                v_reg <= v_minus_u >> 1;
            end
        end
    end

    assign g    = g_reg;
    assign done = done_reg;

endmodule

// ===== rtl/crat_datapath.sv =====
// ----------------------------------------------------------------------------
// crat_datapath
// operand registers, shared multiplier, accumulators, gcd and divider units
// ----------------------------------------------------------------------------
module crat_datapath import crat_pkg::*; #(
    parameter int PART_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  crat_cmd_t                    cmd,
    output crat_stat_t                   stat,
    input  logic [1:0]                   s_opcode,
    input  logic signed [PART_WIDTH-1:0] s_a_re_num,
    input  logic [PART_WIDTH-2:0]        s_a_re_den,
    input  logic signed [PART_WIDTH-1:0] s_a_im_num,
    input  logic [PART_WIDTH-2:0]        s_a_im_den,
    input  logic signed [PART_WIDTH-1:0] s_b_re_num,
    input  logic [PART_WIDTH-2:0]        s_b_re_den,
    input  logic signed [PART_WIDTH-1:0] s_b_im_num,
    input  logic [PART_WIDTH-2:0]        s_b_im_den,
    output logic signed [31:0]           m_sum_re_num,
    output logic [29:0]                  m_sum_re_den,
    output logic signed [31:0]           m_sum_im_num,
    output logic [29:0]                  m_sum_im_den,
    output logic                         m_less_flag
);

    localparam int P  = PART_WIDTH;
    localparam int NW = 2 * P;
    localparam int MW = 2 * P - 1;
    localparam int PW = 2 * P + 2;

    logic [1:0]            op_reg;
    logic signed [P-1:0]   arn_reg, ain_reg, brn_reg, bin_reg;
    logic [P-2:0]          ard_reg, aid_reg, brd_reg, bid_reg;

    logic signed [P:0]     ma, mb;
    logic signed [PW-1:0]  prod_next, prod_reg;
    logic [3:0]            mul_sel_reg;
    logic [NW-1:0]         prod_lo;

    logic signed [NW-1:0]  rn_reg, in_reg;
    logic [MW-1:0]         rd_reg, id_reg;
    logic [NW-1:0]         sa_reg, sb_reg;
    logic [P-1:0]          x1_reg, y1_reg, x2_reg, y2_reg;
    logic [MW-1:0]         qrn_reg, qrd_reg, qin_reg, qid_reg;

    logic [NW-1:0]         rn_abs, in_abs;
    logic [P-1:0]          arn_abs, ain_abs, brn_abs, bin_abs;

    logic [MW-1:0]         gcd_x, gcd_y, gcd_g;
    logic                  gcd_done;
    logic [MW-1:0]         div_n, div_d, div_q;
    logic                  div_done;
    logic [2:0]            div_sel_reg;

    // operand capture on input transfer
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            op_reg  <= s_opcode;
            arn_reg <= s_a_re_num;
            ard_reg <= s_a_re_den;
            ain_reg <= s_a_im_num;
            aid_reg <= s_a_im_den;
            brn_reg <= s_b_re_num;
            brd_reg <= s_b_re_den;
            bin_reg <= s_b_im_num;
            bid_reg <= s_b_im_den;
        end
    end

    // magnitudes
    assign arn_abs = arn_reg[P-1] ? (~arn_reg + 1'b1) : arn_reg;
    assign ain_abs = ain_reg[P-1] ? (~ain_reg + 1'b1) : ain_reg;
    assign brn_abs = brn_reg[P-1] ? (~brn_reg + 1'b1) : brn_reg;
    assign bin_abs = bin_reg[P-1] ? (~bin_reg + 1'b1) : bin_reg;
    assign rn_abs  = rn_reg[NW-1] ? (~rn_reg + 1'b1) : rn_reg;
    assign in_abs  = in_reg[NW-1] ? (~in_reg + 1'b1) : in_reg;

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (cmd.mul_sel)
            MUL_RE_P1: begin ma = signed'({arn_reg[P-1], arn_reg}); mb = signed'({2'b00, brd_reg}); end
            MUL_RE_P2: begin ma = signed'({brn_reg[P-1], brn_reg}); mb = signed'({2'b00, ard_reg}); end
            MUL_IM_P1: begin ma = signed'({ain_reg[P-1], ain_reg}); mb = signed'({2'b00, bid_reg}); end
            MUL_IM_P2: begin ma = signed'({bin_reg[P-1], bin_reg}); mb = signed'({2'b00, aid_reg}); end
            MUL_RE_D:  begin ma = signed'({2'b00, ard_reg}); mb = signed'({2'b00, brd_reg}); end
            MUL_IM_D:  begin ma = signed'({2'b00, aid_reg}); mb = signed'({2'b00, bid_reg}); end
            MUL_SQ_X1: begin ma = signed'({1'b0, x1_reg}); mb = signed'({1'b0, x1_reg}); end
            MUL_SQ_Y1: begin ma = signed'({1'b0, y1_reg}); mb = signed'({1'b0, y1_reg}); end
            MUL_SQ_X2: begin ma = signed'({1'b0, x2_reg}); mb = signed'({1'b0, x2_reg}); end
            MUL_SQ_Y2: begin ma = signed'({1'b0, y2_reg}); mb = signed'({1'b0, y2_reg}); end
            default:   begin ma = '0; mb = '0; end
        endcase
    end

    assign prod_next = ma * mb;
    assign prod_lo   = prod_reg[NW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg    <= prod_next;
            mul_sel_reg <= cmd.mul_sel;
        end
    end

    // accumulate the registered product
    always_ff @(posedge aclk) begin
        if (cmd.acc_en) begin
            unique case (mul_sel_reg)
                MUL_RE_P1: rn_reg <= signed'(prod_lo);
                MUL_RE_P2: rn_reg <= (op_reg == OP_SUB) ? rn_reg - signed'(prod_lo)
                                                        : rn_reg + signed'(prod_lo);
                MUL_IM_P1: in_reg <= signed'(prod_lo);
                MUL_IM_P2: in_reg <= (op_reg == OP_SUB) ? in_reg - signed'(prod_lo)
                                                        : in_reg + signed'(prod_lo);
                MUL_RE_D:  rd_reg <= prod_reg[MW-1:0];
                MUL_IM_D:  id_reg <= prod_reg[MW-1:0];
                MUL_SQ_X1: sa_reg <= prod_lo;
                MUL_SQ_Y1: sa_reg <= sa_reg + prod_lo;
                MUL_SQ_X2: sb_reg <= prod_lo;
                MUL_SQ_Y2: sb_reg <= sb_reg + prod_lo;
                default:   ;
            endcase
        end
    end

    // gcd of one part
    assign gcd_x = cmd.gcd_part ? in_abs[MW-1:0] : rn_abs[MW-1:0];
    assign gcd_y = cmd.gcd_part ? id_reg : rd_reg;

    crat_gcd #(
        .WIDTH (MW)
    ) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.gcd_start),
        .x       (gcd_x),
        .y       (gcd_y),
        .g       (gcd_g),
        .done    (gcd_done)
    );

    // divider operand select
    always_comb begin
        div_n = '0;
        div_d = '0;
        unique case (cmd.div_sel)
            DIV_RE_N: begin div_n = rn_abs[MW-1:0]; div_d = gcd_g; end
            DIV_RE_D: begin div_n = rd_reg;         div_d = gcd_g; end
            DIV_IM_N: begin div_n = in_abs[MW-1:0]; div_d = gcd_g; end
            DIV_IM_D: begin div_n = id_reg;         div_d = gcd_g; end
            DIV_X1:   begin div_n = MW'(arn_abs); div_d = MW'(ard_reg); end
            DIV_Y1:   begin div_n = MW'(ain_abs); div_d = MW'(aid_reg); end
            DIV_X2:   begin div_n = MW'(brn_abs); div_d = MW'(brd_reg); end
            DIV_Y2:   begin div_n = MW'(bin_abs); div_d = MW'(bid_reg); end
            default:  begin div_n = '0; div_d = '0; end
        endcase
    end

    crat_div #(
        .WIDTH (MW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_sel_reg <= cmd.div_sel;
        end
    end

    // store quotient; a zero denominator gives a zero part in compare
    always_ff @(posedge aclk) begin
        if (div_done) begin
            unique case (div_sel_reg)
                DIV_RE_N: qrn_reg <= div_q;
                DIV_RE_D: qrd_reg <= div_q;
                DIV_IM_N: qin_reg <= div_q;
                DIV_IM_D: qid_reg <= div_q;
                DIV_X1:   x1_reg  <= (ard_reg == '0) ? '0 : div_q[P-1:0];
                DIV_Y1:   y1_reg  <= (aid_reg == '0) ? '0 : div_q[P-1:0];
                DIV_X2:   x2_reg  <= (brd_reg == '0) ? '0 : div_q[P-1:0];
                DIV_Y2:   y2_reg  <= (bid_reg == '0) ? '0 : div_q[P-1:0];
                default:  ;
            endcase
        end
    end

    assign stat.gcd_done = gcd_done;
    assign stat.div_done = div_done;

    // restore sign and fit to output widths
    logic [NW-1:0]        re_u, im_u, re_v, im_v;
    logic signed [NW-1:0] re_s, im_s;
    logic signed [63:0]   re_ext, im_ext;
    logic [63:0]          rd_ext, id_ext;

    assign re_u   = NW'(qrn_reg);
    assign im_u   = NW'(qin_reg);
    assign re_v   = rn_reg[NW-1] ? (~re_u + 1'b1) : re_u;
    assign im_v   = in_reg[NW-1] ? (~im_u + 1'b1) : im_u;
    assign re_s   = signed'(re_v);
    assign im_s   = signed'(im_v);
    assign re_ext = 64'(re_s);
    assign im_ext = 64'(im_s);
    assign rd_ext = 64'(qrd_reg);
    assign id_ext = 64'(qid_reg);

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (op_reg == OP_ADD || op_reg == OP_SUB) begin
                m_sum_re_num <= re_ext[31:0];
                m_sum_re_den <= rd_ext[29:0];
                m_sum_im_num <= im_ext[31:0];
                m_sum_im_den <= id_ext[29:0];
            end else begin
                m_sum_re_num <= '0;
                m_sum_re_den <= '0;
                m_sum_im_num <= '0;
                m_sum_im_den <= '0;
            end
            m_less_flag <= (op_reg == OP_COMPARE) && (sa_reg < sb_reg);
        end
    end

endmodule

// ===== rtl/crat_ctrl.sv =====
// ----------------------------------------------------------------------------
// crat_ctrl
// sequencer for multiply, gcd and divide steps and the output handshake
// ----------------------------------------------------------------------------
module crat_ctrl import crat_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    output logic       m_valid,
    input  logic       m_ready,
    input  crat_stat_t stat,
    output crat_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL      = 3'd1;
    localparam logic [2:0] ST_ACC      = 3'd2;
    localparam logic [2:0] ST_GCD      = 3'd3;
    localparam logic [2:0] ST_GCD_WAIT = 3'd4;
    localparam logic [2:0] ST_DIV      = 3'd5;
    localparam logic [2:0] ST_DIV_WAIT = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [3:0] mul_idx_reg, mul_idx_next;
    logic [2:0] div_idx_reg, div_idx_next;
    logic       part_reg, part_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        mul_idx_next = mul_idx_reg;
        div_idx_next = div_idx_reg;
        part_next    = part_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_sel  = mul_idx_reg;
        cmd.div_sel  = div_idx_reg;
        cmd.gcd_part = part_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    if (s_opcode == OP_ADD || s_opcode == OP_SUB) begin
                        mul_idx_next = MUL_RE_P1;
                        state_next   = ST_MUL;
                    end else if (s_opcode == OP_COMPARE) begin
                        div_idx_next = DIV_X1;
                        state_next   = ST_DIV;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                if (mul_idx_reg == MUL_IM_D) begin
                    part_next  = 1'b0;
                    state_next = ST_GCD;
                end else if (mul_idx_reg == MUL_SQ_Y2) begin
                    state_next = ST_DONE;
                end else begin
                    mul_idx_next = mul_idx_reg + 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_GCD: begin
                cmd.gcd_start = 1'b1;
                state_next    = ST_GCD_WAIT;
            end
            ST_GCD_WAIT: begin
                if (stat.gcd_done) begin
                    div_idx_next = part_reg ? DIV_IM_N : DIV_RE_N;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    if (div_idx_reg == DIV_RE_D) begin
                        part_next  = 1'b1;
                        state_next = ST_GCD;
                    end else if (div_idx_reg == DIV_IM_D) begin
                        state_next = ST_DONE;
                    end else if (div_idx_reg == DIV_Y2) begin
                        mul_idx_next = MUL_SQ_X1;
                        state_next   = ST_MUL;
                    end else begin
                        div_idx_next = div_idx_reg + 1'b1;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mul_idx_reg <= '0;
            div_idx_reg <= '0;
            part_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mul_idx_reg <= mul_idx_next;
            div_idx_reg <= div_idx_next;
            part_reg    <= part_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result is only loaded when the output register is free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output loaded over a pending result");

    // unit completions only arrive while waiting on that unit
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider done outside its wait state");

    a_gcd_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.gcd_done |-> (state_reg == ST_GCD_WAIT))
        else $error("gcd done outside its wait state");

    // an accepted item starts work
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start");

endmodule

// ===== sim/complex_rational_add_sub_tb.sv =====
// ----------------------------------------------------------------------------
// complex_rational_add_sub_tb
// self-checking bench for the complex rational add/subtract/compare block
// ----------------------------------------------------------------------------
// A short table of directed operands is followed by random operands. Every
// driven item queues an expected result, typed into its table row or else
// taken from a behavioral predictor. Results are compared in order, field by
// field. Both channels idle at random.
// ----------------------------------------------------------------------------
module complex_rational_add_sub_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crat_pkg::*;

    localparam int PW        = 16;
    localparam int N_RANDOM  = 1750;
    localparam int STALL_MAX = 20000;

    // opcode with no operation behind it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [PW-1:0] arn;
        logic [PW-2:0]        ard;
        logic signed [PW-1:0] ain;
        logic [PW-2:0]        aid;
        logic signed [PW-1:0] brn;
        logic [PW-2:0]        brd;
        logic signed [PW-1:0] bin;
        logic [PW-2:0]        bid;
    } operands_t;

    typedef struct packed {
        logic signed [31:0] re_num;
        logic [29:0]        re_den;
        logic signed [31:0] im_num;
        logic [29:0]        im_den;
        logic               less;
    } rat_result_t;

    typedef struct {
        operands_t   ops;
        bit          has_exp;
        rat_result_t exp;
    } vec_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    operands_t s_ops = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_sum_re_num;
    logic [29:0] m_sum_re_den;
    logic signed [31:0] m_sum_im_num;
    logic [29:0] m_sum_im_den;
    logic m_less_flag;

    rat_result_t sum_queue[$];
    vec_row_t    vec_table[$];
    int          errors = 0;
    int          stall_cnt = 0;
    bit          stim_done = 0;

    always #2 aclk = ~aclk;

    complex_rational_add_sub #(.PART_WIDTH(PW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_ops.op),
        .s_a_re_num(s_ops.arn), .s_a_re_den(s_ops.ard),
        .s_a_im_num(s_ops.ain), .s_a_im_den(s_ops.aid),
        .s_b_re_num(s_ops.brn), .s_b_re_den(s_ops.brd),
        .s_b_im_num(s_ops.bin), .s_b_im_den(s_ops.bid),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sum_re_num(m_sum_re_num), .m_sum_re_den(m_sum_re_den),
        .m_sum_im_num(m_sum_im_num), .m_sum_im_den(m_sum_im_den),
        .m_less_flag(m_less_flag)
    );

    // euclid, with one as divisor when either side is zero
    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        if (x == 0 || y == 0) return 1;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic longint unsigned abs_of(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // reduce one part to lowest terms
    function automatic void reduce_part(input longint n, input longint unsigned d,
                                        output logic [31:0] on, output logic [29:0] od);
        longint unsigned g;
        longint rn;
        g = gcd_of(abs_of(n), d);
        rn = n / longint'(g);
        on = rn[31:0];
        od = 30'(d / g);
    endfunction

    function automatic longint unsigned trunc_mag(longint n, longint unsigned d);
        if (d == 0) return 0;
        return abs_of(n) / d;
    endfunction

    // expected result of one operand set
    function automatic rat_result_t predict_sum(operands_t o);
        rat_result_t r;
        longint p1, p2, q1, q2, rn, imn;
        longint unsigned x1, y1, x2, y2;
        r = '0;
        if (o.op == OP_ADD || o.op == OP_SUB) begin
            p1 = longint'(o.arn) * longint'({1'b0, o.brd});
            p2 = longint'(o.brn) * longint'({1'b0, o.ard});
            q1 = longint'(o.ain) * longint'({1'b0, o.bid});
            q2 = longint'(o.bin) * longint'({1'b0, o.aid});
            rn = (o.op == OP_ADD) ? p1 + p2 : p1 - p2;
            imn = (o.op == OP_ADD) ? q1 + q2 : q1 - q2;
            reduce_part(rn, longint'(o.ard) * longint'(o.brd), r.re_num, r.re_den);
            reduce_part(imn, longint'(o.aid) * longint'(o.bid), r.im_num, r.im_den);
        end else if (o.op == OP_COMPARE) begin
            x1 = trunc_mag(o.arn, o.ard);
            y1 = trunc_mag(o.ain, o.aid);
            x2 = trunc_mag(o.brn, o.brd);
            y2 = trunc_mag(o.bin, o.bid);
            r.less = (x1 * x1 + y1 * y1) < (x2 * x2 + y2 * y2);
        end
        return r;
    endfunction

    function automatic logic [PW-2:0] rand_den();
        case ($urandom_range(0, 5))
            0: return 15'(1);
            1: return 15'h7fff;
            2: return 15'($urandom_range(1, 16));
            3: return 15'(0);
            default: return 15'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic logic signed [PW-1:0] rand_num();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(0);
            3: return 16'($urandom_range(0, 40)) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_op();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return OP_UNUSED;
        if (k < 8) return OP_ADD;
        if (k < 14) return OP_SUB;
        return OP_COMPARE;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 300);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    // one directed row; expected result typed in when has_exp is set
    task automatic add_row(logic [1:0] op, int arn, int ard, int ain, int aid,
                           int brn, int brd, int bin, int bid,
                           bit has_exp = 0, rat_result_t exp = '0);
        vec_row_t row;
        row.ops = '{op, 16'(arn), 15'(ard), 16'(ain), 15'(aid),
                    16'(brn), 15'(brd), 16'(bin), 15'(bid)};
        row.has_exp = has_exp;
        row.exp = exp;
        vec_table.push_back(row);
    endtask

    // drive one input transfer with a random gap ahead
    task automatic send_item(operands_t o, bit has_exp, rat_result_t exp);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ops <= o;
        sum_queue.push_back(has_exp ? exp : predict_sum(o));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stimulus
    initial begin
        operands_t o;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(OP_ADD, 1, 2, 1, 3, 1, 2, 1, 3, 1,
                '{32'sd1, 30'd1, 32'sd2, 30'd3, 1'b0});
        add_row(OP_SUB, 1, 2, 1, 3, 1, 2, 1, 3, 1,
                '{32'sd0, 30'd4, 32'sd0, 30'd9, 1'b0});
        add_row(OP_ADD, 0, 5, 0, 7, 0, 3, 0, 1, 1,
                '{32'sd0, 30'd15, 32'sd0, 30'd7, 1'b0});
        add_row(OP_ADD, -32768, 1, 32767, 1, -32768, 1, 32767, 1, 1,
                '{-32'sd65536, 30'd1, 32'sd65534, 30'd1, 1'b0});
        add_row(OP_SUB, 32767, 32767, -32768, 32767, -32768, 32767, 32767, 32767);
        add_row(OP_ADD, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_row(OP_ADD, 5, 0, 3, 0, 7, 2, 1, 4);
        add_row(OP_SUB, 5, 0, 0, 0, 7, 0, -3, 0);
        add_row(OP_ADD, -7, 3, 11, 13, 5, 9, -1, 32767);
        add_row(OP_UNUSED, 100, 7, -3, 2, 9, 9, 9, 9, 1, '0);
        add_row(OP_UNUSED, -32768, 32767, 32767, 1, -1, 1, 0, 0, 1, '0);
        add_row(OP_COMPARE, 1, 1, 1, 1, 2, 1, 0, 1, 1,
                '{32'sd0, 30'd0, 32'sd0, 30'd0, 1'b1});
        add_row(OP_COMPARE, 2, 1, 0, 1, 1, 1, 1, 1, 1,
                '{32'sd0, 30'd0, 32'sd0, 30'd0, 1'b0});
        add_row(OP_COMPARE, 3, 1, 4, 1, -4, 1, -3, 1, 1, '0);
        add_row(OP_COMPARE, 7, 0, 7, 0, 1, 1, 0, 1, 1,
                '{32'sd0, 30'd0, 32'sd0, 30'd0, 1'b1});
        add_row(OP_COMPARE, -32768, 1, -32768, 1, 32767, 1, 32767, 1);
        add_row(OP_COMPARE, 32767, 1, 32767, 1, -32768, 1, -32768, 1);
        add_row(OP_COMPARE, 5, 3, -5, 3, 1, 2, 1, 2);
        add_row(OP_SUB, -32768, 32767, 0, 1, 32767, 1, -32768, 32767);
        add_row(OP_ADD, 6, 4, -9, 6, 10, 8, 15, 10);

        foreach (vec_table[i])
            send_item(vec_table[i].ops, vec_table[i].has_exp, vec_table[i].exp);

        for (int i = 0; i < N_RANDOM; i++) begin
            o.op  = rand_op();
            o.arn = rand_num();
            o.ard = rand_den();
            o.ain = rand_num();
            o.aid = rand_den();
            o.brn = rand_num();
            o.brd = rand_den();
            o.bin = rand_num();
            o.bid = rand_den();
            send_item(o, 0, '0);
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    // result side: random back-pressure
    initial begin
        int g;
        forever begin
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // compare each output transfer with the oldest expectation
    always @(posedge aclk) begin
        rat_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_sum_re_num, m_sum_re_den, m_sum_im_num, m_sum_im_den, m_less_flag};
            if (sum_queue.size() == 0) begin
                errors++;
                $display("%0t unexpected result %p", $realtime, got);
            end else begin
                want = sum_queue.pop_front();
                if (got.re_num !== want.re_num)
                    $display("%0t re_num expected %0d actual %0d", $realtime,
                             want.re_num, got.re_num);
                if (got.re_den !== want.re_den)
                    $display("%0t re_den expected %0d actual %0d", $realtime,
                             want.re_den, got.re_den);
                if (got.im_num !== want.im_num)
                    $display("%0t im_num expected %0d actual %0d", $realtime,
                             want.im_num, got.im_num);
                if (got.im_den !== want.im_den)
                    $display("%0t im_den expected %0d actual %0d", $realtime,
                             want.im_den, got.im_den);
                if (got.less !== want.less)
                    $display("%0t less_flag expected %0d actual %0d", $realtime,
                             want.less, got.less);
                if (got !== want) errors++;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (sum_queue.size() == 0);
        repeat (600) @(posedge aclk);
        if (errors == 0 && sum_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/crat_pkg.sv
rtl/crat_div.sv
rtl/crat_gcd.sv
rtl/crat_datapath.sv
rtl/crat_ctrl.sv
rtl/complex_rational_add_sub.sv
sim/complex_rational_add_sub_tb.sv
